[sv/mupi_pkg.sv]
// Shared types and constants for the mutex table with priority inheritance.
// No dependencies.
`default_nettype none
package mupi_pkg;
    localparam int NUM_MUTEXES = 16;
    localparam int NUM_PROCS   = 16;
    localparam int PRIO_BITS   = 8;

    localparam logic [2:0] ST_ACQUIRED  = 3'd0;
    localparam logic [2:0] ST_ALREADY   = 3'd1;
    localparam logic [2:0] ST_BLOCKED   = 3'd2;
    localparam logic [2:0] ST_FREED     = 3'd3;
    localparam logic [2:0] ST_HANDED    = 3'd4;
    localparam logic [2:0] ST_NOTLOCKED = 3'd5;
    localparam logic [2:0] ST_NOTOWNER  = 3'd6;
    localparam logic [2:0] ST_REQBLOCK  = 3'd7;

    typedef enum logic [2:0] {
        S_IDLE, S_RDP, S_DEC, S_OWNRD, S_SCAN, S_HREAD, S_HDONE, S_FIN
    } state_t;

    typedef struct packed {
        logic       we;
        logic [3:0] waddr;
        logic [7:0] wdata;
        logic       set_valid;
    } prio_wr_t;

    typedef struct packed {
        logic [2:0] status;
        logic       wake_valid;
        logic [3:0] wake_proc;
        logic       prio_valid;
        logic [3:0] prio_proc;
        logic [7:0] prio_value;
    } result_t;
endpackage
`default_nettype wire

[sv/mupi_prio_store.sv]
// Effective priority store: synchronous-read memory plus per-process valid bits.
// Depends on mupi_pkg.
`default_nettype none
module mupi_prio_store (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire mupi_pkg::prio_wr_t wr,
    input  wire logic [3:0]         raddr,
    output logic [7:0]              rdata,
    output logic [15:0]             valid
);
    logic [7:0]  mem [16];
    logic [15:0] valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.waddr] <= wr.wdata;
        end
        rdata <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr.set_valid)
        begin
            valid_reg[wr.waddr] <= 1'b1;
        end
    end

    assign valid = valid_reg;
endmodule
`default_nettype wire

[sv/mutex_unit_priority_inherit_top.sv]
// Top level of the mutex table: request sequencer, wait queue memory, owner state.
// Depends on mupi_pkg and mupi_prio_store.
//
// Usage: requests (func, mutex_id, proc_id, req_prio) arrive on a valid/stall
// channel; one result per request leaves on a valid/stall channel. The user must
// write inherit_enable over cfg_valid/cfg_ready/cfg_data only while no request is
// in flight; the block itself does not enforce this. Without stalls a request
// passes S_RDP and S_DEC and ends in S_FIN: a grant or a rejected request goes
// straight there, a lock that blocks passes S_OWNRD, an unlock that frees the
// mutex passes S_HREAD, and a hand-over passes S_HREAD and S_HDONE. An unlock
// with inheritance on first scans in S_SCAN every waiter of each mutex the owner
// still holds, one wait queue read per cycle, through the single read port of the
// wait queue memory, then drains the fifo read, priority read and compare steps.
// Requests are taken one at a time; in_stall is high while one is in work.
// The result sits in an output register; if the receiver stalls, the next
// request is still taken and finishes up to its result, which then waits.
// Reset clears ownership, queues, blocked marks and inheritance enable; the
// queue and priority memories need no clearing.
`default_nettype none
module mutex_unit_priority_inherit_top (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic       func,
    input  wire logic [3:0] mutex_id,
    input  wire logic [3:0] proc_id,
    input  wire logic [7:0] req_prio,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [2:0]      status,
    output logic            wake_valid,
    output logic [3:0]      wake_proc,
    output logic            prio_valid,
    output logic [3:0]      prio_proc,
    output logic [7:0]      prio_value,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic       cfg_data
);
    mupi_pkg::state_t state_reg, state_next;

    logic        inherit_reg;
    logic        owner_valid_reg [16];
    logic [3:0]  owner_proc_reg  [16];
    logic [3:0]  head_reg        [16];
    logic [4:0]  count_reg       [16];
    logic        blocked_reg     [16];
    logic [15:0] mask_reg        [16];

    logic [3:0]  fifo_mem [256];
    logic [7:0]  fifo_waddr, fifo_raddr;
    logic [3:0]  fifo_wdata, fifo_rdata;
    logic        fifo_we;

    logic        func_reg, bad_reg;
    logic [3:0]  m_reg, p_reg, own_reg;
    logic [7:0]  base_reg, pprio_reg, best_reg;
    logic [4:0]  k_reg, i_reg;
    logic        v1_reg, v2_reg, ev2_reg;
    mupi_pkg::result_t res_reg, out_reg;
    logic        out_valid_reg;

    mupi_pkg::prio_wr_t prio_wr;
    logic [3:0]  prio_raddr;
    logic [7:0]  prio_rdata;
    logic [15:0] prio_vld;

    logic        accept, out_free, in_range;
    logic [3:0]  own, k4, i4;
    logic        scan_issue, scan_done;
    logic [2:0]  dec_status;

    mupi_prio_store u_prio (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (prio_wr),
        .raddr (prio_raddr),
        .rdata (prio_rdata),
        .valid (prio_vld)
    );

    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg != mupi_pkg::S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || !out_stall;
    assign in_range  = (32'(mutex_id) < mupi_pkg::NUM_MUTEXES) &&
                       (32'(proc_id) < mupi_pkg::NUM_PROCS);
    assign own       = owner_proc_reg[m_reg];
    assign k4        = k_reg[3:0];
    assign i4        = i_reg[3:0];
    assign scan_issue = !k_reg[4] && mask_reg[p_reg][k4] && (i_reg < count_reg[k4]);
    assign scan_done  = k_reg[4] && !v1_reg && !v2_reg;

    // status decided in S_DEC
    always_comb
    begin
        dec_status = mupi_pkg::ST_ACQUIRED;
        if (bad_reg)
            dec_status = mupi_pkg::ST_NOTLOCKED;
        else if (blocked_reg[p_reg])
            dec_status = mupi_pkg::ST_REQBLOCK;
        else if (!func_reg)
        begin
            if (!owner_valid_reg[m_reg])
                dec_status = mupi_pkg::ST_ACQUIRED;
            else if (own == p_reg)
                dec_status = mupi_pkg::ST_ALREADY;
            else if (count_reg[m_reg][4])
                dec_status = mupi_pkg::ST_REQBLOCK;
            else
                dec_status = mupi_pkg::ST_BLOCKED;
        end
        else if (!owner_valid_reg[m_reg])
            dec_status = mupi_pkg::ST_NOTLOCKED;
        else if (own != p_reg)
            dec_status = mupi_pkg::ST_NOTOWNER;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mupi_pkg::S_IDLE:  if (accept) state_next = mupi_pkg::S_RDP;
            mupi_pkg::S_RDP:   state_next = mupi_pkg::S_DEC;
            mupi_pkg::S_DEC:
            begin
                state_next = mupi_pkg::S_FIN;
                if (!bad_reg && !blocked_reg[p_reg] && owner_valid_reg[m_reg])
                begin
                    if (!func_reg)
                    begin
                        if (own != p_reg && !count_reg[m_reg][4])
                            state_next = mupi_pkg::S_OWNRD;
                    end
                    else if (own == p_reg)
                    begin
                        state_next = inherit_reg ? mupi_pkg::S_SCAN : mupi_pkg::S_HREAD;
                    end
                end
            end
            mupi_pkg::S_OWNRD: state_next = mupi_pkg::S_FIN;
            mupi_pkg::S_SCAN:  if (scan_done) state_next = mupi_pkg::S_HREAD;
            mupi_pkg::S_HREAD:
                state_next = (count_reg[m_reg] != 5'd0) ? mupi_pkg::S_HDONE : mupi_pkg::S_FIN;
            mupi_pkg::S_HDONE: state_next = mupi_pkg::S_FIN;
            mupi_pkg::S_FIN:   if (out_free) state_next = mupi_pkg::S_IDLE;
            default:           state_next = mupi_pkg::S_IDLE;
        endcase
    end

    // memory port control
    always_comb
    begin
        prio_wr    = '0;
        prio_raddr = p_reg;
        fifo_we    = 1'b0;
        fifo_waddr = {m_reg, head_reg[m_reg] + count_reg[m_reg][3:0]};
        fifo_wdata = p_reg;
        fifo_raddr = {m_reg, head_reg[m_reg]};
        unique case (state_reg)
            mupi_pkg::S_IDLE:
            begin
                // first sight of a process loads its base priority
                if (accept && in_range && !prio_vld[proc_id])
                begin
                    prio_wr.we        = 1'b1;
                    prio_wr.set_valid = 1'b1;
                    prio_wr.waddr     = proc_id;
                    prio_wr.wdata     = req_prio;
                end
            end
            mupi_pkg::S_DEC:
            begin
                prio_raddr = own;
                fifo_we = (state_next == mupi_pkg::S_OWNRD);
            end
            mupi_pkg::S_OWNRD:
            begin
                if (inherit_reg && prio_vld[own_reg] && pprio_reg < prio_rdata)
                begin
                    prio_wr.we    = 1'b1;
                    prio_wr.waddr = own_reg;
                    prio_wr.wdata = pprio_reg;
                end
            end
            mupi_pkg::S_SCAN:
            begin
                prio_raddr = fifo_rdata;
                fifo_raddr = {k4, head_reg[k4] + i4};
                if (scan_done && best_reg != pprio_reg)
                begin
                    prio_wr.we    = 1'b1;
                    prio_wr.waddr = p_reg;
                    prio_wr.wdata = best_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (fifo_we)
        begin
            fifo_mem[fifo_waddr] <= fifo_wdata;
        end
        fifo_rdata <= fifo_mem[fifo_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mupi_pkg::S_IDLE;
            inherit_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            for (int j = 0; j < 16; j++)
            begin
                owner_valid_reg[j] <= 1'b0;
                owner_proc_reg[j]  <= '0;
                head_reg[j]        <= '0;
                count_reg[j]       <= '0;
                blocked_reg[j]     <= 1'b0;
                mask_reg[j]        <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
                inherit_reg <= cfg_data;
            if (state_reg == mupi_pkg::S_FIN && out_free)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                mupi_pkg::S_IDLE:
                begin
                    if (accept)
                    begin
                        func_reg <= func;
                        m_reg    <= mutex_id;
                        p_reg    <= proc_id;
                        base_reg <= req_prio;
                        bad_reg  <= !in_range;
                    end
                end
                mupi_pkg::S_RDP: ;
                mupi_pkg::S_DEC:
                begin
                    pprio_reg <= prio_rdata;
                    own_reg   <= own;
                    res_reg   <= {dec_status, 18'd0};
                    k_reg     <= '0;
                    i_reg     <= '0;
                    best_reg  <= base_reg;
                    v1_reg    <= 1'b0;
                    v2_reg    <= 1'b0;
                    if (bad_reg || blocked_reg[p_reg])
                        ;
                    else if (!func_reg)
                    begin
                        if (!owner_valid_reg[m_reg])
                        begin
                            owner_valid_reg[m_reg] <= 1'b1;
                            owner_proc_reg[m_reg]  <= p_reg;
                            mask_reg[p_reg][m_reg] <= 1'b1;
                        end
                        else if (own != p_reg && !count_reg[m_reg][4])
                        begin
                            count_reg[m_reg]   <= count_reg[m_reg] + 5'd1;
                            blocked_reg[p_reg] <= 1'b1;
                        end
                    end
                    else if (owner_valid_reg[m_reg] && own == p_reg)
                        mask_reg[p_reg][m_reg] <= 1'b0;
                end
                mupi_pkg::S_OWNRD:
                begin
                    if (prio_wr.we)
                        res_reg <= {res_reg.status, res_reg.wake_valid, res_reg.wake_proc,
                                    1'b1, own_reg, pprio_reg};
                end
                mupi_pkg::S_SCAN:
                begin
                    // fifo read -> priority read -> compare, one waiter per cycle
                    v1_reg  <= scan_issue;
                    v2_reg  <= v1_reg;
                    ev2_reg <= prio_vld[fifo_rdata];
                    if (v2_reg && ev2_reg && prio_rdata < best_reg)
                        best_reg <= prio_rdata;
                    if (scan_issue)
                        i_reg <= i_reg + 5'd1;
                    else if (!k_reg[4])
                    begin
                        k_reg <= k_reg + 5'd1;
                        i_reg <= '0;
                    end
                    if (prio_wr.we)
                        res_reg <= {res_reg.status, res_reg.wake_valid, res_reg.wake_proc,
                                    1'b1, p_reg, best_reg};
                end
                mupi_pkg::S_HREAD:
                begin
                    if (count_reg[m_reg] == 5'd0)
                    begin
                        owner_valid_reg[m_reg] <= 1'b0;
                        owner_proc_reg[m_reg]  <= '0;
                        res_reg.status <= mupi_pkg::ST_FREED;
                    end
                end
                mupi_pkg::S_HDONE:
                begin
                    head_reg[m_reg]       <= head_reg[m_reg] + 4'd1;
                    count_reg[m_reg]      <= count_reg[m_reg] - 5'd1;
                    owner_proc_reg[m_reg] <= fifo_rdata;
                    mask_reg[fifo_rdata][m_reg] <= 1'b1;
                    blocked_reg[fifo_rdata]     <= 1'b0;
                    res_reg <= {mupi_pkg::ST_HANDED, 1'b1, fifo_rdata, res_reg.prio_valid,
                                res_reg.prio_proc, res_reg.prio_value};
                end
                mupi_pkg::S_FIN:
                begin
                    if (out_free)
                        out_reg <= res_reg;
                end
                default: ;
            endcase
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = out_reg.status;
    assign wake_valid = out_reg.wake_valid;
    assign wake_proc  = out_reg.wake_proc;
    assign prio_valid = out_reg.prio_valid;
    assign prio_proc  = out_reg.prio_proc;
    assign prio_value = out_reg.prio_value;
endmodule
`default_nettype wire
